### design/dtt_pkg.sv
package dtt_pkg;

	// Field widths of the channels
	localparam int CMD_W  = 2;
	localparam int DL_W   = 32;
	localparam int HDL_W  = 4;
	localparam int TAG_W  = 16;
	localparam int KIND_W = 3;
	localparam int SLOT_W = 4;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_CREATED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DELETED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd4;

	// Expiries emitted per tick at most, and the width of a count up to it
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = 5;

	// One result transaction
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  user_tag;
		logic [DL_W-1:0]   deadline;
		logic              last;
	} dtt_result_t;

endpackage

### design/dtt_in_if.sv
interface dtt_in_if;
	logic                        valid;
	logic                        ready;
	logic [dtt_pkg::CMD_W-1:0]   cmd;
	logic [dtt_pkg::DL_W-1:0]    delay;
	logic [dtt_pkg::HDL_W-1:0]   handle;
	logic [dtt_pkg::TAG_W-1:0]   tag;

	modport source (output valid, output cmd, output delay, output handle, output tag,
		input ready);
	modport sink (input valid, input cmd, input delay, input handle, input tag,
		output ready);
endinterface

### design/dtt_out_if.sv
interface dtt_out_if;
	logic                        valid;
	logic                        ready;
	logic [dtt_pkg::KIND_W-1:0]  kind;
	logic [dtt_pkg::SLOT_W-1:0]  slot;
	logic [dtt_pkg::TAG_W-1:0]   user_tag;
	logic [dtt_pkg::DL_W-1:0]    deadline;
	logic                        last;

	modport source (output valid, output kind, output slot, output user_tag,
		output deadline, output last, input ready);
	modport sink (input valid, input kind, input slot, input user_tag,
		input deadline, input last, output ready);
endinterface

### design/deadline_timer_table.sv
// Create scans the valid flags for the lowest free slot; delete reads its slot; tick finds
// the earliest deadline, then idles or expires up to MAX_RESULTS, at most one per cycle.
// Throughput: one command at a time; a command is taken once the previous one has handed
// all its results to the output register. The scans step through the slot memory, one slot
// read per cycle on its single read port; the expiry scan pauses while the output is full.
// Reset: tick counter and slot valid flags clear at once; no clearing pass over the memory.
module deadline_timer_table #(
	parameter int MAX_TIMERS = 16,
	parameter int TAG_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	dtt_in_if.sink    cmd_ch,
	dtt_out_if.source res_ch
);

	localparam int SW = $clog2(MAX_TIMERS);
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam int DW = dtt_pkg::DL_W;
	localparam int RW = dtt_pkg::RES_CNT_W;
	localparam int MW = DW + TAG_BITS;
	localparam logic [SW-1:0] LAST_IDX = SW'(MAX_TIMERS - 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FIND = 3'd1;
	localparam logic [2:0] ST_CRT  = 3'd2;
	localparam logic [2:0] ST_DEL  = 3'd3;
	localparam logic [2:0] ST_ONE  = 3'd4;
	localparam logic [2:0] ST_MIN  = 3'd5;
	localparam logic [2:0] ST_DEC  = 3'd6;
	localparam logic [2:0] ST_EXP  = 3'd7;

	logic [2:0]                  state_q;
	logic [DW-1:0]               now_q;
	logic [MAX_TIMERS-1:0]       valid_q;
	logic [SW-1:0]               idx_q;
	logic                        iss_done_q;
	logic                        v_s1;
	logic [SW-1:0]               idx_s1;
	logic [DW-1:0]               delay_q;
	logic [TAG_BITS-1:0]         tag_q;
	logic [dtt_pkg::KIND_W-1:0]  kind_q;
	logic                        any_q;
	logic [DW-1:0]               min_q;
	logic [CW-1:0]               cnt_q;
	logic [RW-1:0]               target_q;
	logic [RW-1:0]               n_q;

	logic                        in_fire;
	logic [8:0]                  handle_w;
	logic [SW-1:0]               h_idx;
	logic                        h_ok;
	logic [63:0]                 tag_in_w;
	logic [8:0]                  cnt_w;
	logic [DW-1:0]               s1_dl;
	logic [TAG_BITS-1:0]         s1_tag;
	logic                        s1_live;
	logic                        hit_s1;
	logic                        advance;
	logic                        last_hit;
	logic                        out_free;
	logic                        push;
	dtt_pkg::dtt_result_t        res;
	logic [SW-1:0]               res_idx;
	logic [8:0]                  res_idx_w;
	logic [TAG_BITS-1:0]         res_tag;
	logic [63:0]                 res_tag_w;
	logic [DW-1:0]               new_dl;

	logic                        rd_en;
	logic [SW-1:0]               rd_addr;
	logic [MW-1:0]               rd_data;
	logic                        wr_en;

	// Input decode
	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign in_fire      = cmd_ch.valid && cmd_ch.ready;
	assign handle_w     = 9'(cmd_ch.handle);
	assign h_idx        = handle_w[SW-1:0];
	assign h_ok         = (handle_w < 9'(MAX_TIMERS)) && valid_q[h_idx];
	assign tag_in_w     = 64'(cmd_ch.tag);
	assign new_dl       = now_q + delay_q;
	assign cnt_w        = 9'(cnt_q);

	// Read stage
	assign s1_dl    = rd_data[MW-1:TAG_BITS];
	assign s1_tag   = rd_data[TAG_BITS-1:0];
	assign s1_live  = v_s1 && valid_q[idx_s1];
	assign hit_s1   = (state_q == ST_EXP) && s1_live && (s1_dl == min_q);
	assign advance  = !(hit_s1 && !out_free);
	assign last_hit = (RW'(n_q + 1'b1) == target_q);

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			ST_IDLE: begin
				rd_en   = in_fire && (cmd_ch.cmd == dtt_pkg::CMD_DELETE) && h_ok;
				rd_addr = h_idx;
			end
			ST_MIN:  rd_en = !iss_done_q;
			ST_EXP:  rd_en = advance && !iss_done_q;
			default: rd_en = 1'b0;
		endcase
	end

	assign wr_en = (state_q == ST_CRT) && out_free;

	dtt_mem #(
		.DEPTH (MAX_TIMERS),
		.WIDTH (MW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_q),
		.wr_data ({new_dl, tag_q})
	);

	// Result assembly
	always_comb begin
		push    = 1'b0;
		res_idx = idx_q;
		res_tag = s1_tag;
		res     = '0;
		case (state_q)
			ST_CRT: begin
				push         = out_free;
				res_tag      = tag_q;
				res.kind     = dtt_pkg::KIND_CREATED;
				res.deadline = new_dl;
				res.last     = 1'b1;
			end
			ST_DEL: begin
				push         = out_free;
				res.kind     = dtt_pkg::KIND_DELETED;
				res.deadline = s1_dl;
				res.last     = 1'b1;
			end
			ST_ONE: begin
				push     = out_free;
				res.kind = kind_q;
				res.last = 1'b1;
			end
			ST_EXP: begin
				push         = hit_s1 && out_free;
				res_idx      = idx_s1;
				res.kind     = dtt_pkg::KIND_EXPIRED;
				res.deadline = min_q;
				res.last     = last_hit;
			end
			default: push = 1'b0;
		endcase
		if (state_q != ST_ONE) begin
			res.slot     = res_idx_w[dtt_pkg::SLOT_W-1:0];
			res.user_tag = res_tag_w[dtt_pkg::TAG_W-1:0];
		end
	end

	assign res_idx_w = 9'(res_idx);
	assign res_tag_w = 64'(res_tag);

	dtt_outreg u_outreg (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.free   (out_free),
		.res_ch (res_ch)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			valid_q    <= '0;
			idx_q      <= '0;
			iss_done_q <= 1'b0;
			v_s1       <= 1'b0;
			idx_s1     <= '0;
			delay_q    <= '0;
			tag_q      <= '0;
			kind_q     <= dtt_pkg::KIND_ERROR;
			any_q      <= 1'b0;
			min_q      <= '0;
			cnt_q      <= '0;
			target_q   <= '0;
			n_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (cmd_ch.cmd)
							dtt_pkg::CMD_CREATE: begin
								delay_q <= cmd_ch.delay;
								tag_q   <= tag_in_w[TAG_BITS-1:0];
								idx_q   <= '0;
								state_q <= ST_FIND;
							end
							dtt_pkg::CMD_DELETE: begin
								if (h_ok) begin
									idx_q   <= h_idx;
									state_q <= ST_DEL;
								end else begin
									kind_q  <= dtt_pkg::KIND_ERROR;
									state_q <= ST_ONE;
								end
							end
							dtt_pkg::CMD_TICK: begin
								now_q      <= now_q + 1'b1;
								idx_q      <= '0;
								iss_done_q <= 1'b0;
								v_s1       <= 1'b0;
								any_q      <= 1'b0;
								cnt_q      <= '0;
								state_q    <= ST_MIN;
							end
							default: begin
								kind_q  <= dtt_pkg::KIND_ERROR;
								state_q <= ST_ONE;
							end
						endcase
					end
				end
				// lowest free slot, one valid flag a cycle
				ST_FIND: begin
					if (!valid_q[idx_q]) begin
						state_q <= ST_CRT;
					end else if (idx_q == LAST_IDX) begin
						kind_q  <= dtt_pkg::KIND_ERROR;
						state_q <= ST_ONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CRT: begin
					if (out_free) begin
						valid_q[idx_q] <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_DEL: begin
					if (out_free) begin
						valid_q[idx_q] <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				ST_ONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				// first pass: earliest deadline and how many slots share it
				ST_MIN: begin
					v_s1   <= !iss_done_q;
					idx_s1 <= idx_q;
					if (!iss_done_q) begin
						if (idx_q == LAST_IDX) begin
							iss_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (s1_live) begin
						if (!any_q || (s1_dl < min_q)) begin
							min_q <= s1_dl;
							cnt_q <= CW'(1);
							any_q <= 1'b1;
						end else if (s1_dl == min_q) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (v_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (!any_q || (now_q < min_q)) begin
						kind_q  <= dtt_pkg::KIND_IDLE;
						state_q <= ST_ONE;
					end else begin
						target_q   <= (cnt_w > 9'(dtt_pkg::MAX_RESULTS)) ?
							RW'(dtt_pkg::MAX_RESULTS) : cnt_w[RW-1:0];
						n_q        <= '0;
						idx_q      <= '0;
						iss_done_q <= 1'b0;
						v_s1       <= 1'b0;
						state_q    <= ST_EXP;
					end
				end
				// second pass: expire the group, up to MAX_RESULTS, in slot order, stalls on a full output
				ST_EXP: begin
					if (advance) begin
						// the stage empties once the final expiry goes out
						v_s1   <= !iss_done_q && !(hit_s1 && last_hit);
						idx_s1 <= idx_q;
						if (!iss_done_q) begin
							if (idx_q == LAST_IDX) begin
								iss_done_q <= 1'b1;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						if (hit_s1) begin
							valid_q[idx_s1] <= 1'b0;
							n_q             <= RW'(n_q + 1'b1);
							if (last_hit) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/dtt_mem.sv
// Slot store: one write port, one read port with registered, enabled read data
module dtt_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/dtt_outreg.sv
// Output register: holds one result transaction until the sink takes it
module dtt_outreg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dtt_pkg::dtt_result_t res,
	output logic                 free,
	dtt_out_if.source            res_ch
);

	logic                 valid_q;
	dtt_pkg::dtt_result_t res_q;

	assign free = !valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign res_ch.valid    = valid_q;
	assign res_ch.kind     = res_q.kind;
	assign res_ch.slot     = res_q.slot;
	assign res_ch.user_tag = res_q.user_tag;
	assign res_ch.deadline = res_q.deadline;
	assign res_ch.last     = res_q.last;

endmodule
